// ===== rtl/mep_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape-time pixel unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mep_pkg;

    localparam int FIXED_WIDTH   = 32;
    localparam int FRACTION_BITS = 28;
    localparam int COORD_BITS    = 12;
    localparam int COUNT_BITS    = 16;
    localparam int VIEW_BITS     = 13;
    localparam int STEP_BITS     = 31;
    localparam int GRAY_BITS     = 8;
    localparam int PROD_WIDTH    = 2 * FIXED_WIDTH;
    localparam int NUMER_BITS    = COUNT_BITS + GRAY_BITS;
    localparam int CFG_IDX_BITS  = 3;

    typedef logic signed [FIXED_WIDTH-1:0] fx_t;

    localparam fx_t FX_MAX = fx_t'({1'b0, {(FIXED_WIDTH-1){1'b1}}});
    localparam fx_t FX_MIN = fx_t'({1'b1, {(FIXED_WIDTH-1){1'b0}}});

    // escape bound 4.0 in the fraction format, one bit wider than a square
    localparam logic [FIXED_WIDTH:0] ESCAPE_BOUND = (FIXED_WIDTH+1)'(4) << FRACTION_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_RE  = 3'd0,
        CFG_CENTER_IM  = 3'd1,
        CFG_PIXEL_STEP = 3'd2,
        CFG_VIEW_W     = 3'd3,
        CFG_VIEW_H     = 3'd4,
        CFG_ITER_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAPX,
        ST_MAPY,
        ST_MAPC,
        ST_UPD,
        ST_MRR,
        ST_MII,
        ST_MRI,
        ST_DIV,
        ST_DONE
    } mep_state_t;

    typedef struct packed {
        fx_t  a;
        fx_t  b;
        logic half;
    } mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [NUMER_BITS-1:0] numer;
        logic [COUNT_BITS-1:0] denom;
    } div_req_t;

    function automatic fx_t sat_add(fx_t a, fx_t b);
        logic [FIXED_WIDTH:0] sum;
        fx_t                  res;
        sum = {a[FIXED_WIDTH-1], a} + {b[FIXED_WIDTH-1], b};
        if (sum[FIXED_WIDTH] != sum[FIXED_WIDTH-1])
        begin
            res = sum[FIXED_WIDTH] ? FX_MIN : FX_MAX;
        end
        else
        begin
            res = fx_t'(sum[FIXED_WIDTH-1:0]);
        end
        return res;
    endfunction

endpackage

// ===== rtl/mandelbrot_escape_pixel_unit.sv =====
// Mandelbrot escape-time pixel unit: sequencer, view registers and result beat.
// Uses mep_pkg, mep_mul_unit and mep_gray_div.
//
// Usage:
//   cfg_*  : register writes, index 0..5 = center_re, center_im, pixel_step,
//            view_width, view_height, iteration_limit; always ready. Write only
//            while no pixel is in flight.
//   s_*    : one beat per pixel, tdata = {pixel_y, pixel_x}. s_tready is high
//            only while the sequencer is idle.
//   m_*    : one result beat per pixel, tdata = {gray_level, escape_count},
//            tuser = inside_set.
// Sequence: one shared multiplier does every product. Mapping runs through
//   MAPX, MAPY and MAPC, each iteration through UPD, MRR, MII and MRI (three
//   products and the z update), then the gray divide when the point escaped
//   before the limit, and DONE loads the output register. The next pixel is
//   taken in the cycle after that load.
// Reset loads the default view and clears all control state; no beat is
//   pending afterwards. A stalled receiver holds the result beat in the output
//   register; the next pixel is still accepted and computed, and its result
//   waits until the held beat is taken.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] escape_count, [23:16] gray_level
    output logic        m_tuser    // [0] inside_set
);
    import mep_pkg::*;

    fx_t                    center_re_reg;
    fx_t                    center_im_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [VIEW_BITS-1:0]   view_w_reg;
    logic [VIEW_BITS-1:0]   view_h_reg;
    logic [COUNT_BITS-1:0]  limit_reg;
    logic [COUNT_BITS-1:0]  lim_eff;

    mep_state_t             state_reg;
    mep_state_t             state_next;

    logic [COORD_BITS-1:0]  px_reg;
    logic [COORD_BITS-1:0]  py_reg;
    fx_t                    cr_reg;
    fx_t                    ci_reg;
    fx_t                    zr_reg;
    fx_t                    zi_reg;
    fx_t                    rr_reg;
    fx_t                    ii_reg;
    logic [COUNT_BITS-1:0]  iter_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   inside_reg;
    logic [GRAY_BITS-1:0]   gray_reg;
    logic                   div_pend_reg;

    logic                   out_valid_reg;
    logic [23:0]            out_data_reg;
    logic                   out_inside_reg;

    logic signed [COORD_BITS+1:0] dx;
    logic signed [COORD_BITS+1:0] dy;
    mul_req_t               mreq;
    fx_t                    mres;
    div_req_t               dreq;
    logic                   div_done;
    logic [GRAY_BITS-1:0]   div_q;
    fx_t                    ri;
    logic                   escape;
    logic                   at_limit;
    logic                   out_free;

    assign lim_eff  = (limit_reg == '0) ? COUNT_BITS'(1) : limit_reg;
    assign dx = $signed({1'b0, px_reg, 1'b0}) - $signed((COORD_BITS+2)'(view_w_reg));
    assign dy = $signed({1'b0, py_reg, 1'b0}) - $signed((COORD_BITS+2)'(view_h_reg));
    assign ri       = (iter_reg == COUNT_BITS'(1)) ? '0 : mres;
    assign escape   = ({1'b0, rr_reg} + {1'b0, mres}) > ESCAPE_BOUND;
    assign at_limit = (iter_reg == lim_eff);
    assign out_free = !out_valid_reg || m_tready;

    // ---- configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_re_reg <= fx_t'(441233);
            center_im_reg <= fx_t'(220779474);
            step_reg      <= STEP_BITS'(1342177);
            view_w_reg    <= VIEW_BITS'(500);
            view_h_reg    <= VIEW_BITS'(500);
            limit_reg     <= COUNT_BITS'(30);
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_RE:  center_re_reg <= fx_t'(cfg_data);
                CFG_CENTER_IM:  center_im_reg <= fx_t'(cfg_data);
                CFG_PIXEL_STEP: step_reg      <= cfg_data[STEP_BITS-1:0];
                CFG_VIEW_W:     view_w_reg    <= cfg_data[VIEW_BITS-1:0];
                CFG_VIEW_H:     view_h_reg    <= cfg_data[VIEW_BITS-1:0];
                CFG_ITER_LIMIT: limit_reg     <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---- shared units
    mep_mul_unit u_mul (
        .clk (clk),
        .req (mreq),
        .res (mres)
    );

    mep_gray_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        mreq.a      = zr_reg;
        mreq.b      = zr_reg;
        mreq.half   = 1'b0;
        dreq.start  = 1'b0;
        dreq.numer  = {count_reg, GRAY_BITS'(0)} - NUMER_BITS'(count_reg);
        dreq.denom  = lim_eff;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_MAPX;
                end
            end
            ST_MAPX:
            begin
                mreq.a     = fx_t'(dx);
                mreq.b     = fx_t'({1'b0, step_reg});
                mreq.half  = 1'b1;
                state_next = ST_MAPY;
            end
            ST_MAPY:
            begin
                mreq.a     = fx_t'(dy);
                mreq.b     = fx_t'({1'b0, step_reg});
                mreq.half  = 1'b1;
                state_next = ST_MAPC;
            end
            ST_MAPC: state_next = ST_UPD;
            ST_UPD:  state_next = ST_MRR;
            ST_MRR:  state_next = ST_MII;
            ST_MII:
            begin
                mreq.a     = zi_reg;
                mreq.b     = zi_reg;
                state_next = ST_MRI;
            end
            ST_MRI:
            begin
                mreq.a = zr_reg;
                mreq.b = zi_reg;
                if (escape && !at_limit)
                begin
                    state_next = ST_DIV;
                end
                else if (escape || at_limit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_DIV:
            begin
                // launch the divide once the count is settled
                dreq.start = div_pend_reg;
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // divide starts on the first DIV cycle, count_reg is valid then
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_pend_reg <= 1'b0;
        end
        else
        begin
            div_pend_reg <= (state_reg == ST_MRI) && escape && !at_limit;
        end
    end

    // ---- datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                px_reg <= s_tdata[COORD_BITS-1:0];
                py_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            end
            ST_MAPY: cr_reg <= sat_add(center_re_reg, mres);
            ST_MAPC:
            begin
                ci_reg   <= sat_add(center_im_reg, mres);
                rr_reg   <= '0;
                ii_reg   <= '0;
                iter_reg <= COUNT_BITS'(1);
            end
            ST_UPD:
            begin
                zr_reg <= sat_add(sat_add(rr_reg, -ii_reg), cr_reg);
                zi_reg <= sat_add(sat_add(ri, ri), ci_reg);
            end
            ST_MII: rr_reg <= mres;
            ST_MRI:
            begin
                ii_reg     <= mres;
                count_reg  <= iter_reg;
                inside_reg <= !escape;
                gray_reg   <= '0;
                iter_reg   <= iter_reg + COUNT_BITS'(1);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    gray_reg <= div_q;
                end
            end
            default: ;
        endcase
    end

    // ---- result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg   <= {gray_reg, count_reg};
            out_inside_reg <= inside_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_inside_reg;

    // ---- checks
    a_inside_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[23:16] == '0))
        else $error("inside point with nonzero gray level");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] != '0 && m_tdata[15:0] <= lim_eff))
        else $error("escape count out of range");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MRI) |-> (iter_reg <= lim_eff))
        else $error("iteration counter passed the limit");

endmodule

// ===== rtl/mep_mul_unit.sv =====
// Shared signed multiplier: product, arithmetic right shift, clamp to fixed width.
// Registered result. Depends on mep_pkg.
`timescale 1ns / 1ps

module mep_mul_unit (
    input  logic              clk,
    input  mep_pkg::mul_req_t req,
    output mep_pkg::fx_t      res
);
    import mep_pkg::*;

    logic signed [PROD_WIDTH-1:0] product;
    logic signed [PROD_WIDTH-1:0] shifted;
    fx_t                          clamped;
    fx_t                          res_reg;

    assign product = req.a * req.b;
    assign shifted = req.half ? (product >>> 1) : (product >>> FRACTION_BITS);

    always_comb
    begin
        if ((&shifted[PROD_WIDTH-1:FIXED_WIDTH-1]) || !(|shifted[PROD_WIDTH-1:FIXED_WIDTH-1]))
        begin
            clamped = fx_t'(shifted[FIXED_WIDTH-1:0]);
        end
        else
        begin
            clamped = shifted[PROD_WIDTH-1] ? FX_MIN : FX_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= clamped;
    end

    assign res = res_reg;

endmodule

// ===== rtl/mep_gray_div.sv =====
// Restoring divider for the gray level, one quotient bit per cycle.
// Quotient must fit in eight bits. Depends on mep_pkg.
`timescale 1ns / 1ps

module mep_gray_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mep_pkg::div_req_t              req,
    output logic                           done,
    output logic [mep_pkg::GRAY_BITS-1:0]  quotient
);
    import mep_pkg::*;

    logic [NUMER_BITS-1:0] rem_reg;
    logic [NUMER_BITS-1:0] den_reg;
    logic [GRAY_BITS-1:0]  quo_reg;
    logic [2:0]            step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [NUMER_BITS:0]   diff;

    assign diff = {1'b0, rem_reg} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.numer;
            den_reg <= NUMER_BITS'({req.denom, 7'b0});
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[NUMER_BITS])
            begin
                rem_reg <= diff[NUMER_BITS-1:0];
            end
            quo_reg <= {quo_reg[GRAY_BITS-2:0], !diff[NUMER_BITS]};
            den_reg <= den_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== bench/mep_escape_checker.sv =====
// Scoreboard for the Mandelbrot escape-time pixel unit. It mirrors the view registers,
// predicts escape count, inside flag and gray level per pixel and checks result beats in order.
// Depends on mep_pkg.
`timescale 1ns / 1ps

module mep_escape_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [15:0] escape_count, [23:16] gray_level
    input  logic        m_tuser,   // [0] inside_set
    output int          errors,
    output int          pending,
    output int          results_checked,
    output int          inside_seen
);
    import mep_pkg::*;

    localparam int     GRAY_FULL = 255;
    localparam longint ESCAPE_SQ = longint'(4) << FRACTION_BITS;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  in_set;
        logic [GRAY_BITS-1:0]  gray;
    } escape_t;

    fx_t                   view_re;
    fx_t                   view_im;
    logic [STEP_BITS-1:0]  step;
    logic [VIEW_BITS-1:0]  span_x;
    logic [VIEW_BITS-1:0]  span_y;
    logic [COUNT_BITS-1:0] iter_cap;
    escape_t               expected_q[$];
    int                    err_cnt;
    int                    done_cnt;
    int                    inside_cnt;

    function automatic fx_t clamp_fx(longint v);
        if (v > longint'(FX_MAX))
            return FX_MAX;
        if (v < longint'(FX_MIN))
            return FX_MIN;
        return fx_t'(v);
    endfunction

    function automatic fx_t add_fx(fx_t a, fx_t b);
        return clamp_fx(longint'(a) + longint'(b));
    endfunction

    // floor of the double-width product, then saturate
    function automatic fx_t mul_fx(fx_t a, fx_t b);
        return clamp_fx((longint'(a) * longint'(b)) >>> FRACTION_BITS);
    endfunction

    function automatic fx_t map_axis(logic [COORD_BITS-1:0] pix, logic [VIEW_BITS-1:0] span,
                                     fx_t ctr);
        longint delta;
        longint prod;
        delta = 2 * longint'(pix) - longint'(span);
        prod  = delta * longint'(step);
        return add_fx(ctr, clamp_fx(prod >>> 1));
    endfunction

    function automatic escape_t escape_of(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
        escape_t res;
        fx_t     cr;
        fx_t     ci;
        fx_t     zr;
        fx_t     zi;
        fx_t     rr;
        fx_t     ii;
        fx_t     ri;
        int      cap;
        int      cnt;
        bit      escaped;
        cr      = map_axis(px, span_x, view_re);
        ci      = map_axis(py, span_y, view_im);
        zr      = '0;
        zi      = '0;
        cap     = (iter_cap == '0) ? 1 : int'(iter_cap);
        cnt     = cap;
        escaped = 1'b0;
        for (int n = 1; n <= cap; n++)
        begin
            rr = mul_fx(zr, zr);
            ii = mul_fx(zi, zi);
            ri = mul_fx(zr, zi);
            zr = add_fx(add_fx(rr, -ii), cr);
            zi = add_fx(add_fx(ri, ri), ci);
            rr = mul_fx(zr, zr);
            ii = mul_fx(zi, zi);
            if (longint'(rr) + longint'(ii) > ESCAPE_SQ)
            begin
                escaped = 1'b1;
                cnt     = n;
                break;
            end
        end
        res.count  = cnt[COUNT_BITS-1:0];
        res.in_set = !escaped;
        res.gray   = (cnt == cap) ? '0 : GRAY_BITS'((cnt * GRAY_FULL) / cap);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        escape_t want;
        escape_t got;
        if (!rst_n)
        begin
            view_re    = 32'sd441233;
            view_im    = 32'sd220779474;
            step       = 31'd1342177;
            span_x     = 13'd500;
            span_y     = 13'd500;
            iter_cap   = 16'd30;
            expected_q.delete();
            err_cnt    = 0;
            done_cnt   = 0;
            inside_cnt = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CENTER_RE:  view_re  = fx_t'(cfg_data);
                    CFG_CENTER_IM:  view_im  = fx_t'(cfg_data);
                    CFG_PIXEL_STEP: step     = cfg_data[STEP_BITS-1:0];
                    CFG_VIEW_W:     span_x   = cfg_data[VIEW_BITS-1:0];
                    CFG_VIEW_H:     span_y   = cfg_data[VIEW_BITS-1:0];
                    CFG_ITER_LIMIT: iter_cap = cfg_data[COUNT_BITS-1:0];
                    default:        ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(escape_of(s_tdata[COORD_BITS-1:0],
                                               s_tdata[2*COORD_BITS-1:COORD_BITS]));
            end
            if (m_tvalid && m_tready)
            begin
                got.count  = m_tdata[COUNT_BITS-1:0];
                got.gray   = m_tdata[COUNT_BITS+GRAY_BITS-1:COUNT_BITS];
                got.in_set = m_tuser;
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result beat with no pixel pending: count %0d inside %0b gray %0d",
                             $time, got.count, got.in_set, got.gray);
                end
                else
                begin
                    want = expected_q.pop_front();
                    done_cnt++;
                    if (want.in_set)
                        inside_cnt++;
                    if (got.count !== want.count)
                    begin
                        err_cnt++;
                        $display("%0t: escape_count expected %0d, got %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.in_set !== want.in_set)
                    begin
                        err_cnt++;
                        $display("%0t: inside_set expected %0b, got %0b",
                                 $time, want.in_set, got.in_set);
                    end
                    if (got.gray !== want.gray)
                    begin
                        err_cnt++;
                        $display("%0t: gray_level expected %0d, got %0d",
                                 $time, want.gray, got.gray);
                    end
                end
            end
        end
        errors          <= err_cnt;
        pending         <= expected_q.size();
        results_checked <= done_cnt;
        inside_seen     <= inside_cnt;
    end

endmodule

// ===== bench/mandelbrot_escape_pixel_unit_tb.sv =====
// Testbench top for the Mandelbrot escape-time pixel unit: clock, reset, view register
// writes, pixel stimulus, output backpressure and verdict. Uses mep_pkg and mep_escape_checker.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit_tb;
    import mep_pkg::*;

    localparam int          IDLE_LIMIT   = 1_200_000;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          PRESSURE_AT  = 60;
    localparam int          PRESSURE_LEN = 1500;
    localparam logic [2:0]  CFG_SPARE    = 3'd7;
    localparam fx_t         FX_TWO_HALF  = 32'sd671088640;
    localparam fx_t         FX_QUARTER   = 32'sd67108864;
    localparam fx_t         FX_NEG_HALF  = -32'sd134217728;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [11:0] pixel_x, [23:12] pixel_y
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [15:0] escape_count, [23:16] gray_level
    logic        m_tuser;          // [0] inside_set

    int fail_total;
    int pending_pixels;
    int results_checked;
    int inside_seen;
    int pixels_sent = 0;
    int views_loaded = 0;
    int cur_vw = 500;
    int cur_vh = 500;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mandelbrot_escape_pixel_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mep_escape_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .errors          (fail_total),
        .pending         (pending_pixels),
        .results_checked (results_checked),
        .inside_seen     (inside_seen)
    );

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic load_view(fx_t cre, fx_t cim, logic [STEP_BITS-1:0] step,
                             logic [VIEW_BITS-1:0] vw, logic [VIEW_BITS-1:0] vh,
                             logic [COUNT_BITS-1:0] lim, bit spare);
        logic [2:0]  idx[7];
        logic [31:0] val[7];
        int          first;
        idx[0] = CFG_SPARE;      val[0] = $urandom;
        idx[1] = CFG_CENTER_RE;  val[1] = cre;
        idx[2] = CFG_CENTER_IM;  val[2] = cim;
        idx[3] = CFG_PIXEL_STEP; val[3] = 32'(step);
        idx[4] = CFG_VIEW_W;     val[4] = 32'(vw);
        idx[5] = CFG_VIEW_H;     val[5] = 32'(vh);
        idx[6] = CFG_ITER_LIMIT; val[6] = 32'(lim);
        first  = spare ? 0 : 1;
        for (int i = first; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_vw = (vw == '0) ? 1 : ((vw > 13'd4096) ? 4096 : int'(vw));
        cur_vh = (vh == '0) ? 1 : ((vh > 13'd4096) ? 4096 : int'(vh));
        views_loaded++;
    endtask

    task automatic send_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                              bit gapless);
        int gap;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // drop valid and hold until every result is back
    task automatic finish_scan();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_pixels != 0);
    endtask

    task automatic random_scan(int n, bit gapless);
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        for (int i = 0; i < n; i++)
        begin
            px = ($urandom_range(0, 4) != 0) ? COORD_BITS'($urandom_range(0, cur_vw - 1))
                                              : COORD_BITS'($urandom_range(0, 4095));
            py = ($urandom_range(0, 4) != 0) ? COORD_BITS'($urandom_range(0, cur_vh - 1))
                                              : COORD_BITS'($urandom_range(0, 4095));
            send_pixel(px, py, gapless);
        end
        finish_scan();
    endtask

    initial
    begin : result_sink
        int taken;
        int hold_left;
        int mode_left;
        int stall_pct;
        int r;
        bit pressured;
        taken     = 0;
        hold_left = 0;
        mode_left = 0;
        stall_pct = 0;
        pressured = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!pressured && taken >= PRESSURE_AT)
            begin
                pressured = 1'b1;
                hold_left = PRESSURE_LEN;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(50, 400);
                    r         = $urandom_range(0, 2);
                    stall_pct = (r == 0) ? 0 : ((r == 1) ? 15 : 50);
                end
                mode_left--;
                r = $urandom_range(0, 999);
                if (stall_pct > 0 && r < 4)
                begin
                    hold_left = $urandom_range(20, 80);
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= (r >= stall_pct * 10);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("mandelbrot_escape_pixel_unit_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view, coordinate extremes and alternating bits
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0);
        send_pixel(12'd0, 12'd4095, 1'b0);
        send_pixel(12'd250, 12'd250, 1'b0);
        send_pixel(12'hAAA, 12'h555, 1'b0);
        finish_scan();

        // zero step at the origin, limit 0 acts as 1
        load_view('0, '0, '0, 13'd500, 13'd500, 16'd0, 1'b1);
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0);
        finish_scan();

        // escape on the only allowed iteration
        load_view(FX_TWO_HALF, '0, 31'd1, 13'd1, 13'd1, 16'd1, 1'b0);
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0);
        finish_scan();

        // saturated mapping at the widest view and largest limit
        load_view(FX_MAX, FX_MIN, 31'h7FFF_FFFF, 13'd4096, 13'd4096, 16'hFFFF, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0);
        send_pixel(12'd0, 12'd4095, 1'b0);
        send_pixel(12'd2048, 12'd2048, 1'b0);
        finish_scan();

        // one pixel that runs the full limit
        load_view('0, '0, '0, 13'd4096, 13'd4096, 16'hFFFF, 1'b0);
        send_pixel(12'd123, 12'd456, 1'b0);
        finish_scan();

        // odd view sizes center on a half pixel
        load_view(FX_QUARTER, FX_NEG_HALF, 31'd3, 13'd7, 13'd5, 16'd16, 1'b0);
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd3, 12'd2, 1'b0);
        send_pixel(12'd4, 12'd3, 1'b0);
        send_pixel(12'd6, 12'd4, 1'b0);
        finish_scan();

        // whole set framed in a small image
        load_view(FX_NEG_HALF, '0, 31'd12582912, 13'd64, 13'd64, 16'd30, 1'b0);
        random_scan(150, 1'b0);

        // zoom on the boundary
        load_view(-32'sd199608605, 32'sd35379793, 31'd65536, 13'd100, 13'd80, 16'd64, 1'b0);
        random_scan(120, 1'b0);

        // random views: back to back, odd sizes, tiny limits
        for (int p = 0; p < 3; p++)
        begin
            load_view(fx_t'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000),
                      fx_t'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000),
                      STEP_BITS'($urandom_range(1, 32'h0100_0000)),
                      VIEW_BITS'($urandom_range(1, 4096)) | VIEW_BITS'(p == 1),
                      VIEW_BITS'($urandom_range(1, 4096)) | VIEW_BITS'(p == 1),
                      COUNT_BITS'($urandom_range((p == 2) ? 0 : 1, (p == 2) ? 2 : 40)),
                      1'b0);
            random_scan(80, p == 0);
        end

        // large steps and arbitrary centers drive the mapping into saturation
        load_view(fx_t'($urandom), fx_t'($urandom),
                  STEP_BITS'($urandom) | 31'h4000_0000,
                  VIEW_BITS'($urandom_range(1, 4096)), VIEW_BITS'($urandom_range(1, 4096)),
                  16'd20, 1'b0);
        random_scan(60, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d pixels over %0d view settings, %0d results checked, %0d inside",
                 pixels_sent, views_loaded, results_checked, inside_seen);
        $display("views spanned zero step, limits 0/1/65535, odd sizes, saturation, long stall");
        if (fail_total == 0)
            $display("mandelbrot_escape_pixel_unit_tb passed");
        else
            $display("mandelbrot_escape_pixel_unit_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mep_pkg.sv
rtl/mep_mul_unit.sv
rtl/mep_gray_div.sv
rtl/mandelbrot_escape_pixel_unit.sv
bench/mep_escape_checker.sv
bench/mandelbrot_escape_pixel_unit_tb.sv
